// ===== src/c_like_token_lexer_macros.svh =====
// ----------------------------------------------------------------------------
// Token lexer assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef C_LIKE_TOKEN_LEXER_MACROS_SVH
`define C_LIKE_TOKEN_LEXER_MACROS_SVH

`ifndef SYNTH

`define CLTL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define CLTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLTL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define CLTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/cltl_pkg.sv =====
// ----------------------------------------------------------------------------
// Token lexer package
// Transfer types, token kinds and keyword spellings for the token lexer.
// ----------------------------------------------------------------------------
package cltl_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       is_end;
    } t_in;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [6:0]  token_char;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last;
    } t_out;

    localparam logic [4:0] K_EOF      = 5'd0;
    localparam logic [4:0] K_LEX      = 5'd1;
    localparam logic [4:0] K_IF       = 5'd2;
    localparam logic [4:0] K_ELSE     = 5'd3;
    localparam logic [4:0] K_WHILE    = 5'd4;
    localparam logic [4:0] K_DO       = 5'd5;
    localparam logic [4:0] K_FOR      = 5'd6;
    localparam logic [4:0] K_ELLIPSIS = 5'd7;
    localparam logic [4:0] K_LE       = 5'd8;
    localparam logic [4:0] K_SHL      = 5'd9;
    localparam logic [4:0] K_A_SHL    = 5'd10;
    localparam logic [4:0] K_GE       = 5'd11;
    localparam logic [4:0] K_SHR      = 5'd12;
    localparam logic [4:0] K_A_SHR    = 5'd13;
    localparam logic [4:0] K_NE       = 5'd14;
    localparam logic [4:0] K_EQ       = 5'd15;
    localparam logic [4:0] K_A_MUL    = 5'd16;
    localparam logic [4:0] K_A_MOD    = 5'd17;
    localparam logic [4:0] K_A_XOR    = 5'd18;
    localparam logic [4:0] K_INC      = 5'd19;
    localparam logic [4:0] K_A_ADD    = 5'd20;
    localparam logic [4:0] K_DEC      = 5'd21;
    localparam logic [4:0] K_A_SUB    = 5'd22;
    localparam logic [4:0] K_ARROW    = 5'd23;
    localparam logic [4:0] K_L_OR     = 5'd24;
    localparam logic [4:0] K_A_OR     = 5'd25;
    localparam logic [4:0] K_L_AND    = 5'd26;
    localparam logic [4:0] K_A_AND    = 5'd27;
    localparam logic [4:0] K_A_DIV    = 5'd28;
    localparam logic [4:0] K_SINGLE   = 5'd29;

    // Keyword spellings, first character in the lowest byte.
    localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
    localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6c65;
    localparam logic [63:0] KW_WHILE = 64'h0000_0065_6c69_6877;
    localparam logic [63:0] KW_DO    = 64'h0000_0000_0000_6f64;
    localparam logic [63:0] KW_FOR   = 64'h0000_0000_0072_6f66;

    localparam logic [7:0] CH_VTAB = 8'h0b;

endpackage

// ===== src/c_like_token_lexer.sv =====
// ----------------------------------------------------------------------------
// C-like token lexer
// Scans source bytes one per transfer and produces tokens with their start
// position and length, using one character of lookahead.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_stall   i_in_data  (cltl_pkg::t_in)
//   output   out        o_out_valid / i_out_stall o_out_data (cltl_pkg::t_out)
//
// One byte is taken every cycle while o_in_stall is low; its scan step completes
// in that cycle and its zero, one or two tokens enter a four-entry result queue.
// The queue drains one token per cycle while i_out_stall is low, so input is
// held off only while fewer than two queue entries are free.
// Synchronous active-low reset returns the scanner to line 1, column 1.
// A stall on the output side fills the queue and then stalls the input.
// ----------------------------------------------------------------------------
`include "c_like_token_lexer_macros.svh"

module c_like_token_lexer #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cltl_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cltl_pkg::t_out  o_out_data
);

    localparam int PB = POSITION_BITS;
    localparam int KB = 8 * KEYWORD_CHARS;
    localparam logic [PB-1:0] POS_ONE = PB'(1);
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    typedef enum logic [4:0] {
        M_IDLE, M_NUM, M_IDENT, M_DOT, M_DOTDOT, M_LT, M_SHL, M_GT, M_SHR,
        M_BANG, M_EQ, M_STAR, M_PCT, M_CARET, M_PLUS, M_MINUS, M_BAR, M_AMP,
        M_SLASH, M_LCOM, M_BCOM
    } t_mode;

    typedef struct packed {
        logic           put;
        logic [4:0]     kind;
        logic [6:0]     ch;
        logic [PB-1:0]  len;
    } t_tok;

    t_mode          r_mode, n_mode;
    logic [KB-1:0]  r_kbuf, n_kbuf;
    logic [PB-1:0]  r_plen, n_plen;
    logic [PB-1:0]  r_tline, n_tline;
    logic [PB-1:0]  r_tcol, n_tcol;
    logic [PB-1:0]  r_cline, n_cline;
    logic [PB-1:0]  r_ccol, n_ccol;
    logic           r_star, n_star;

    cltl_pkg::t_out r_q [0:3];
    logic [1:0]     r_wp, n_wp;
    logic [1:0]     r_rp, n_rp;
    logic [2:0]     r_cnt, n_cnt;

    logic           w_acc;
    logic           w_pop;
    logic [7:0]     w_c;
    t_tok           w_flush;
    t_tok           w_ext;
    logic           w_cons;
    t_mode          w_emode;
    logic           w_eadd;
    logic           w_estar_wr;
    logic [4:0]     w_opk;
    t_mode          w_smode;
    logic           w_sadd;
    logic           w_sput;
    logic [4:0]     w_wkind;
    logic [63:0]    w_kb64;
    cltl_pkg::t_out w_a;
    cltl_pkg::t_out w_b;
    logic           w_av;
    logic           w_bv;
    cltl_pkg::t_out w_res0;
    cltl_pkg::t_out w_res1;
    logic [1:0]     w_nres;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v != POS_MAX) ? v + POS_ONE : v;
    endfunction

    function automatic logic [15:0] to16(input logic [PB-1:0] v);
        logic [PB+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == cltl_pkg::CH_VTAB) ||
               (c == 8'h0c) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

    function automatic cltl_pkg::t_out mk(input logic [4:0] kind, input logic [6:0] ch,
                                          input logic [PB-1:0] line,
                                          input logic [PB-1:0] col,
                                          input logic [PB-1:0] len);
        cltl_pkg::t_out o;
        o.token_kind   = kind;
        o.token_char   = ch;
        o.start_line   = to16(line);
        o.start_column = to16(col);
        o.token_length = to16(len);
        o.last         = 1'b0;
        return o;
    endfunction

    assign w_c   = i_in_data.character;
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_pop = o_out_valid && !i_out_stall;

    assign o_in_stall  = r_cnt > 3'd2;
    assign o_out_valid = r_cnt != 3'd0;
    assign o_out_data  = r_q[r_rp];

    // Keyword lookup on the buffered identifier.
    always_comb begin
        w_kb64 = 64'(r_kbuf);
        if (r_plen == PB'(2) && w_kb64 == cltl_pkg::KW_IF) begin
            w_wkind = cltl_pkg::K_IF;
        end else if (r_plen == PB'(4) && w_kb64 == cltl_pkg::KW_ELSE) begin
            w_wkind = cltl_pkg::K_ELSE;
        end else if (r_plen == PB'(5) && w_kb64 == cltl_pkg::KW_WHILE) begin
            w_wkind = cltl_pkg::K_WHILE;
        end else if (r_plen == PB'(2) && w_kb64 == cltl_pkg::KW_DO) begin
            w_wkind = cltl_pkg::K_DO;
        end else if (r_plen == PB'(3) && w_kb64 == cltl_pkg::KW_FOR) begin
            w_wkind = cltl_pkg::K_FOR;
        end else begin
            w_wkind = cltl_pkg::K_LEX;
        end
    end

    // Token held by the current mode when a byte cannot extend it.
    always_comb begin
        w_flush = '{put: 1'b1, kind: cltl_pkg::K_SINGLE, ch: 7'd0, len: POS_ONE};
        unique case (r_mode)
            M_NUM:   w_flush = '{put: 1'b1, kind: cltl_pkg::K_LEX, ch: 7'd0, len: r_plen};
            M_IDENT: w_flush = '{put: 1'b1, kind: w_wkind, ch: 7'd0, len: r_plen};
            M_DOT:   w_flush.ch = 7'h2e;
            M_LT:    w_flush.ch = 7'h3c;
            M_GT:    w_flush.ch = 7'h3e;
            M_SHL:   w_flush = '{put: 1'b1, kind: cltl_pkg::K_SHL, ch: 7'd0, len: PB'(2)};
            M_SHR:   w_flush = '{put: 1'b1, kind: cltl_pkg::K_SHR, ch: 7'd0, len: PB'(2)};
            M_SLASH: w_flush.ch = 7'h2f;
            M_BANG:  w_flush.ch = 7'h21;
            M_EQ:    w_flush.ch = 7'h3d;
            M_STAR:  w_flush.ch = 7'h2a;
            M_PCT:   w_flush.ch = 7'h25;
            M_CARET: w_flush.ch = 7'h5e;
            M_PLUS:  w_flush.ch = 7'h2b;
            M_MINUS: w_flush.ch = 7'h2d;
            M_BAR:   w_flush.ch = 7'h7c;
            M_AMP:   w_flush.ch = 7'h26;
            default: w_flush.put = 1'b0;
        endcase
    end

    // Second character of the two-character operators.
    always_comb begin
        w_opk = cltl_pkg::K_EOF;
        case (r_mode)
            M_BANG:  if (w_c == "=") w_opk = cltl_pkg::K_NE;
            M_EQ:    if (w_c == "=") w_opk = cltl_pkg::K_EQ;
            M_STAR:  if (w_c == "=") w_opk = cltl_pkg::K_A_MUL;
            M_PCT:   if (w_c == "=") w_opk = cltl_pkg::K_A_MOD;
            M_CARET: if (w_c == "=") w_opk = cltl_pkg::K_A_XOR;
            M_PLUS: begin
                if (w_c == "+") w_opk = cltl_pkg::K_INC;
                else if (w_c == "=") w_opk = cltl_pkg::K_A_ADD;
            end
            M_MINUS: begin
                if (w_c == "-") w_opk = cltl_pkg::K_DEC;
                else if (w_c == "=") w_opk = cltl_pkg::K_A_SUB;
                else if (w_c == ">") w_opk = cltl_pkg::K_ARROW;
            end
            M_BAR: begin
                if (w_c == "|") w_opk = cltl_pkg::K_L_OR;
                else if (w_c == "=") w_opk = cltl_pkg::K_A_OR;
            end
            M_AMP: begin
                if (w_c == "&") w_opk = cltl_pkg::K_L_AND;
                else if (w_c == "=") w_opk = cltl_pkg::K_A_AND;
            end
            default: w_opk = cltl_pkg::K_EOF;
        endcase
    end

    // Continuation of the pending token by the new byte.
    always_comb begin
        w_cons     = 1'b1;
        w_emode    = M_IDLE;
        w_eadd     = 1'b0;
        w_estar_wr = 1'b0;
        w_ext      = '{put: 1'b0, kind: cltl_pkg::K_EOF, ch: 7'd0, len: PB'(2)};
        unique case (r_mode)
            M_NUM: begin
                w_cons  = is_num(w_c);
                w_eadd  = 1'b1;
                w_emode = M_NUM;
            end
            M_IDENT: begin
                w_cons  = is_num(w_c) || is_alpha(w_c);
                w_eadd  = 1'b1;
                w_emode = M_IDENT;
            end
            M_DOT: begin
                w_cons  = w_c == ".";
                w_emode = M_DOTDOT;
            end
            M_DOTDOT: begin
                w_ext = '{put: w_c == ".", kind: cltl_pkg::K_ELLIPSIS, ch: 7'd0, len: PB'(3)};
            end
            M_LT, M_GT: begin
                if (w_c == "=") begin
                    w_ext.put  = 1'b1;
                    w_ext.kind = (r_mode == M_LT) ? cltl_pkg::K_LE : cltl_pkg::K_GE;
                end else if (r_mode == M_LT && w_c == "<") begin
                    w_emode = M_SHL;
                end else if (r_mode == M_GT && w_c == ">") begin
                    w_emode = M_SHR;
                end else begin
                    w_cons = 1'b0;
                end
            end
            M_SHL, M_SHR: begin
                w_cons     = w_c == "=";
                w_ext.put  = 1'b1;
                w_ext.len  = PB'(3);
                w_ext.kind = (r_mode == M_SHL) ? cltl_pkg::K_A_SHL : cltl_pkg::K_A_SHR;
            end
            M_SLASH: begin
                if (w_c == "=") begin
                    w_ext.put  = 1'b1;
                    w_ext.kind = cltl_pkg::K_A_DIV;
                end else if (w_c == "/") begin
                    w_emode = M_LCOM;
                end else if (w_c == "*") begin
                    w_emode    = M_BCOM;
                    w_estar_wr = 1'b1;
                end else begin
                    w_cons = 1'b0;
                end
            end
            M_LCOM: begin
                w_emode = (w_c == 8'h0a) ? M_IDLE : M_LCOM;
            end
            M_BCOM: begin
                w_emode    = (r_star && w_c == "/") ? M_IDLE : M_BCOM;
                w_estar_wr = 1'b1;
            end
            M_BANG, M_EQ, M_STAR, M_PCT, M_CARET, M_PLUS, M_MINUS, M_BAR, M_AMP: begin
                w_cons     = w_opk != cltl_pkg::K_EOF;
                w_ext.put  = 1'b1;
                w_ext.kind = w_opk;
            end
            default: w_cons = 1'b0;
        endcase
    end

    // Opening of a new token from the byte.
    always_comb begin
        w_smode = M_IDLE;
        w_sadd  = 1'b0;
        w_sput  = 1'b0;
        if (is_ws(w_c)) begin
            w_smode = M_IDLE;
        end else if (is_num(w_c)) begin
            w_smode = M_NUM;
            w_sadd  = 1'b1;
        end else if (is_alpha(w_c)) begin
            w_smode = M_IDENT;
            w_sadd  = 1'b1;
        end else begin
            case (w_c) inside
                ".":  w_smode = M_DOT;
                "<":  w_smode = M_LT;
                ">":  w_smode = M_GT;
                "/":  w_smode = M_SLASH;
                "!":  w_smode = M_BANG;
                "=":  w_smode = M_EQ;
                "*":  w_smode = M_STAR;
                "%":  w_smode = M_PCT;
                "^":  w_smode = M_CARET;
                "+":  w_smode = M_PLUS;
                "-":  w_smode = M_MINUS;
                "|":  w_smode = M_BAR;
                "&":  w_smode = M_AMP;
                "(", ")", "[", "]", "{", "}", ",", ";", ":", "?", "~", "@", "$":
                    w_sput = 1'b1;
                default: w_smode = M_IDLE;
            endcase
        end
    end

    // Next state and the results of one transfer.
    always_comb begin
        n_mode  = r_mode;
        n_kbuf  = r_kbuf;
        n_plen  = r_plen;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_cline = r_cline;
        n_ccol  = r_ccol;
        n_star  = r_star;
        w_av    = 1'b0;
        w_bv    = 1'b0;
        w_a     = mk(w_flush.kind, w_flush.ch, r_tline, r_tcol, w_flush.len);
        w_b     = mk(cltl_pkg::K_EOF, 7'd0, r_cline, r_ccol, '0);

        if (i_in_data.is_end) begin
            w_av    = w_flush.put;
            w_bv    = 1'b1;
            n_mode  = M_IDLE;
            n_kbuf  = '0;
            n_plen  = '0;
            n_tline = POS_ONE;
            n_tcol  = POS_ONE;
            n_cline = POS_ONE;
            n_ccol  = POS_ONE;
            n_star  = 1'b0;
        end else begin
            if (w_cons) begin
                n_mode = w_emode;
                if (w_estar_wr) begin
                    n_star = (r_mode == M_BCOM) && (w_c == "*");
                end
                w_av = w_ext.put;
                w_a  = mk(w_ext.kind, 7'd0, r_tline, r_tcol, w_ext.len);
            end else begin
                w_av    = w_flush.put;
                n_mode  = w_smode;
                n_tline = r_cline;
                n_tcol  = r_ccol;
                n_kbuf  = '0;
                n_plen  = '0;
                w_bv    = w_sput;
                w_b     = mk(cltl_pkg::K_SINGLE, w_c[6:0], r_cline, r_ccol, POS_ONE);
            end
            if ((w_cons && w_eadd) || (!w_cons && w_sadd)) begin
                for (int k = 0; k < KEYWORD_CHARS; k++) begin
                    if (n_plen == PB'(k)) begin
                        n_kbuf[8*k +: 8] = w_c;
                    end
                end
                n_plen = sat_inc(n_plen);
            end
            if (w_c == 8'h0a) begin
                n_cline = sat_inc(r_cline);
                n_ccol  = POS_ONE;
            end else begin
                n_ccol = sat_inc(r_ccol);
            end
        end

        w_nres = {1'b0, w_av} + {1'b0, w_bv};
        w_res0 = w_av ? w_a : w_b;
        w_res1 = w_b;
        w_res0.last = w_nres == 2'd1;
        w_res1.last = 1'b1;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_acc) begin
            n_wp = r_wp + w_nres;
        end
        if (w_pop) begin
            n_rp = r_rp + 2'd1;
        end
        n_cnt = r_cnt + (w_acc ? 3'(w_nres) : 3'd0) - (w_pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_kbuf  <= '0;
            r_plen  <= '0;
            r_tline <= POS_ONE;
            r_tcol  <= POS_ONE;
            r_cline <= POS_ONE;
            r_ccol  <= POS_ONE;
            r_star  <= 1'b0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (w_acc) begin
                r_mode  <= n_mode;
                r_kbuf  <= n_kbuf;
                r_plen  <= n_plen;
                r_tline <= n_tline;
                r_tcol  <= n_tcol;
                r_cline <= n_cline;
                r_ccol  <= n_ccol;
                r_star  <= n_star;
            end
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_nres != 2'd0) begin
            r_q[r_wp] <= w_res0;
        end
        if (w_acc && w_nres == 2'd2) begin
            r_q[r_wp + 2'd1] <= w_res1;
        end
    end

    `CLTL_ASSERT_IMPL(a_queue_room, i_clk, i_rst_n, w_acc, ({1'b0, r_cnt} + 4'(w_nres)) <= 4'd4, "result queue overflow")
    `CLTL_ASSERT_IMPL(a_end_yields_eof, i_clk, i_rst_n, w_acc && i_in_data.is_end, w_nres != 2'd0 && w_res1.token_kind == cltl_pkg::K_EOF, "end transfer without eof token")
    `CLTL_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, w_acc && i_in_data.is_end, r_mode == M_IDLE && r_cline == POS_ONE && r_ccol == POS_ONE && r_plen == '0, "scanner not reset after end")
    `CLTL_ASSERT_IMPL(a_pos_nonzero, i_clk, i_rst_n, 1'b1, r_cline != '0 && r_ccol != '0 && r_tline != '0 && r_tcol != '0, "position counter reached zero")

endmodule

// ===== test/c_like_token_lexer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer testbench
// Feeds source bytes and end markers into the lexer and predicts every token,
// with its kind, character, start position, length and last flag. Each token
// leaving the block is checked against the oldest prediction. Directed text,
// random well-formed text with noise and long identifier and line runs are
// covered, and both sides pause and stall at random.
// ----------------------------------------------------------------------------
module c_like_token_lexer_test;

    localparam logic [7:0] CH_NL = 8'h0a;

    typedef enum logic [4:0] {
        SC_IDLE, SC_NUM, SC_IDENT, SC_DOT, SC_DOTDOT, SC_LT, SC_SHL, SC_GT, SC_SHR,
        SC_BANG, SC_EQ, SC_STAR, SC_PCT, SC_CARET, SC_PLUS, SC_MINUS, SC_BAR, SC_AMP,
        SC_SLASH, SC_LCOM, SC_BCOM
    } t_scan;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    cltl_pkg::t_in  in_data   = '0;
    logic           out_stall = 1'b0;
    logic           in_stall;
    logic           out_valid;
    cltl_pkg::t_out out_data;

    t_scan          scan_state;
    logic [39:0]    word_bytes;
    logic [15:0]    word_len;
    logic [15:0]    tok_line;
    logic [15:0]    tok_col;
    logic [15:0]    line_no;
    logic [15:0]    col_no;
    logic           star_last;
    cltl_pkg::t_out due_tokens [$];

    int mismatches = 0;
    int chars_sent = 0;
    int stall_left = 0;
    bit calm       = 1'b0;

    string op_set [48] = '{
        "...", "<=", "<<", "<<=", ">=", ">>", ">>=", "!=", "==", "*=", "%=", "^=",
        "++", "+=", "--", "-=", "->", "||", "|=", "&&", "&=", "/=",
        "(", ")", "[", "]", "{", "}", ",", ";", ":", "?", "~", "@", "$",
        "<", ">", ".", "/", "!", "=", "*", "%", "^", "+", "-", "|", "&"
    };

    c_like_token_lexer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] bump(logic [15:0] v);
        bump = (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    function automatic bit is_num(logic [7:0] c);
        is_num = (c >= "0" && c <= "9");
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        is_blank = c == 8'h20 || c == 8'h09 || c == cltl_pkg::CH_VTAB || c == 8'h0c
                   || c == 8'h0d || c == CH_NL;
    endfunction

    function automatic logic [7:0] op_lead(t_scan s);
        case (s)
            SC_BANG:  op_lead = "!";
            SC_EQ:    op_lead = "=";
            SC_STAR:  op_lead = "*";
            SC_PCT:   op_lead = "%";
            SC_CARET: op_lead = "^";
            SC_PLUS:  op_lead = "+";
            SC_MINUS: op_lead = "-";
            SC_BAR:   op_lead = "|";
            default:  op_lead = "&";
        endcase
    endfunction

    function automatic t_scan op_state(logic [7:0] c);
        case (c)
            "!":     op_state = SC_BANG;
            "=":     op_state = SC_EQ;
            "*":     op_state = SC_STAR;
            "%":     op_state = SC_PCT;
            "^":     op_state = SC_CARET;
            "+":     op_state = SC_PLUS;
            "-":     op_state = SC_MINUS;
            "|":     op_state = SC_BAR;
            "&":     op_state = SC_AMP;
            default: op_state = SC_IDLE;
        endcase
    endfunction

    // Kind of the two-character operator formed by the pending lead and c.
    function automatic logic [4:0] pair_kind(t_scan s, logic [7:0] c);
        pair_kind = cltl_pkg::K_EOF;
        case (s)
            SC_BANG:  if (c == "=") pair_kind = cltl_pkg::K_NE;
            SC_EQ:    if (c == "=") pair_kind = cltl_pkg::K_EQ;
            SC_STAR:  if (c == "=") pair_kind = cltl_pkg::K_A_MUL;
            SC_PCT:   if (c == "=") pair_kind = cltl_pkg::K_A_MOD;
            SC_CARET: if (c == "=") pair_kind = cltl_pkg::K_A_XOR;
            SC_PLUS: begin
                if (c == "+") pair_kind = cltl_pkg::K_INC;
                else if (c == "=") pair_kind = cltl_pkg::K_A_ADD;
            end
            SC_MINUS: begin
                if (c == "-") pair_kind = cltl_pkg::K_DEC;
                else if (c == "=") pair_kind = cltl_pkg::K_A_SUB;
                else if (c == ">") pair_kind = cltl_pkg::K_ARROW;
            end
            SC_BAR: begin
                if (c == "|") pair_kind = cltl_pkg::K_L_OR;
                else if (c == "=") pair_kind = cltl_pkg::K_A_OR;
            end
            SC_AMP: begin
                if (c == "&") pair_kind = cltl_pkg::K_L_AND;
                else if (c == "=") pair_kind = cltl_pkg::K_A_AND;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [4:0] word_kind();
        logic [63:0] w;
        w = {24'd0, word_bytes};
        if (word_len == 16'd2 && w == cltl_pkg::KW_IF) word_kind = cltl_pkg::K_IF;
        else if (word_len == 16'd4 && w == cltl_pkg::KW_ELSE) word_kind = cltl_pkg::K_ELSE;
        else if (word_len == 16'd5 && w == cltl_pkg::KW_WHILE) word_kind = cltl_pkg::K_WHILE;
        else if (word_len == 16'd2 && w == cltl_pkg::KW_DO) word_kind = cltl_pkg::K_DO;
        else if (word_len == 16'd3 && w == cltl_pkg::KW_FOR) word_kind = cltl_pkg::K_FOR;
        else word_kind = cltl_pkg::K_LEX;
    endfunction

    function automatic void reset_scanner();
        scan_state = SC_IDLE;
        word_bytes = '0;
        word_len   = '0;
        tok_line   = 16'd1;
        tok_col    = 16'd1;
        line_no    = 16'd1;
        col_no     = 16'd1;
        star_last  = 1'b0;
    endfunction

    function automatic void push_token(logic [4:0] kind, logic [7:0] ch, logic [15:0] len);
        cltl_pkg::t_out tok;
        tok.token_kind   = kind;
        tok.token_char   = ch[6:0];
        tok.start_line   = tok_line;
        tok.start_column = tok_col;
        tok.token_length = len;
        tok.last         = 1'b0;
        due_tokens.push_back(tok);
    endfunction

    function automatic void add_word_char(logic [7:0] c);
        if (word_len < 16'd5) word_bytes[8*word_len +: 8] = c;
        word_len = bump(word_len);
    endfunction

    function automatic void flush_token();
        case (scan_state)
            SC_NUM:   push_token(cltl_pkg::K_LEX, 8'd0, word_len);
            SC_IDENT: push_token(word_kind(), 8'd0, word_len);
            SC_DOT:   push_token(cltl_pkg::K_SINGLE, ".", 16'd1);
            SC_LT:    push_token(cltl_pkg::K_SINGLE, "<", 16'd1);
            SC_GT:    push_token(cltl_pkg::K_SINGLE, ">", 16'd1);
            SC_SHL:   push_token(cltl_pkg::K_SHL, 8'd0, 16'd2);
            SC_SHR:   push_token(cltl_pkg::K_SHR, 8'd0, 16'd2);
            SC_SLASH: push_token(cltl_pkg::K_SINGLE, "/", 16'd1);
            SC_BANG, SC_EQ, SC_STAR, SC_PCT, SC_CARET, SC_PLUS, SC_MINUS, SC_BAR, SC_AMP:
                push_token(cltl_pkg::K_SINGLE, op_lead(scan_state), 16'd1);
            default: ;
        endcase
        scan_state = SC_IDLE;
        word_bytes = '0;
        word_len   = '0;
    endfunction

    function automatic void begin_token(logic [7:0] c);
        tok_line   = line_no;
        tok_col    = col_no;
        word_bytes = '0;
        word_len   = '0;
        if (is_blank(c)) begin
        end else if (is_num(c)) begin
            scan_state = SC_NUM;
            add_word_char(c);
        end else if (is_alpha(c)) begin
            scan_state = SC_IDENT;
            add_word_char(c);
        end else begin
            case (c)
                ".": scan_state = SC_DOT;
                "<": scan_state = SC_LT;
                ">": scan_state = SC_GT;
                "/": scan_state = SC_SLASH;
                "(", ")", "[", "]", "{", "}", ",", ";", ":", "?", "~", "@", "$":
                    push_token(cltl_pkg::K_SINGLE, c, 16'd1);
                default: scan_state = op_state(c);
            endcase
        end
    endfunction

    // Returns 1 when c extends or completes the pending token.
    function automatic bit continue_token(logic [7:0] c);
        logic [4:0] kind;
        continue_token = 1'b0;
        case (scan_state)
            SC_NUM: begin
                if (is_num(c)) begin
                    add_word_char(c);
                    continue_token = 1'b1;
                end
            end
            SC_IDENT: begin
                if (is_alpha(c) || is_num(c)) begin
                    add_word_char(c);
                    continue_token = 1'b1;
                end
            end
            SC_DOT: begin
                if (c == ".") begin
                    scan_state     = SC_DOTDOT;
                    continue_token = 1'b1;
                end
            end
            SC_DOTDOT: begin
                if (c == ".") push_token(cltl_pkg::K_ELLIPSIS, 8'd0, 16'd3);
                scan_state     = SC_IDLE;
                continue_token = 1'b1;
            end
            SC_LT, SC_GT: begin
                if (c == "=") begin
                    push_token(scan_state == SC_LT ? cltl_pkg::K_LE : cltl_pkg::K_GE,
                               8'd0, 16'd2);
                    scan_state     = SC_IDLE;
                    continue_token = 1'b1;
                end else if (scan_state == SC_LT && c == "<") begin
                    scan_state     = SC_SHL;
                    continue_token = 1'b1;
                end else if (scan_state == SC_GT && c == ">") begin
                    scan_state     = SC_SHR;
                    continue_token = 1'b1;
                end
            end
            SC_SHL, SC_SHR: begin
                if (c == "=") begin
                    push_token(scan_state == SC_SHL ? cltl_pkg::K_A_SHL : cltl_pkg::K_A_SHR,
                               8'd0, 16'd3);
                    scan_state     = SC_IDLE;
                    continue_token = 1'b1;
                end
            end
            SC_SLASH: begin
                if (c == "=") begin
                    push_token(cltl_pkg::K_A_DIV, 8'd0, 16'd2);
                    scan_state     = SC_IDLE;
                    continue_token = 1'b1;
                end else if (c == "/") begin
                    scan_state     = SC_LCOM;
                    continue_token = 1'b1;
                end else if (c == "*") begin
                    scan_state     = SC_BCOM;
                    star_last      = 1'b0;
                    continue_token = 1'b1;
                end
            end
            SC_LCOM: begin
                if (c == CH_NL) scan_state = SC_IDLE;
                continue_token = 1'b1;
            end
            SC_BCOM: begin
                if (star_last && c == "/") scan_state = SC_IDLE;
                star_last      = (c == "*");
                continue_token = 1'b1;
            end
            default: begin
                kind = pair_kind(scan_state, c);
                if (kind != cltl_pkg::K_EOF) begin
                    push_token(kind, 8'd0, 16'd2);
                    scan_state     = SC_IDLE;
                    continue_token = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic void lex_char(cltl_pkg::t_in item);
        int             queued;
        cltl_pkg::t_out tok;
        queued = due_tokens.size();
        if (item.is_end) begin
            flush_token();
            tok_line = line_no;
            tok_col  = col_no;
            push_token(cltl_pkg::K_EOF, 8'd0, 16'd0);
            reset_scanner();
        end else begin
            if (!continue_token(item.character)) begin
                flush_token();
                begin_token(item.character);
            end
            if (item.character == CH_NL) begin
                line_no = bump(line_no);
                col_no  = 16'd1;
            end else begin
                col_no = bump(col_no);
            end
        end
        if (due_tokens.size() > queued) begin
            tok      = due_tokens.pop_back();
            tok.last = 1'b1;
            due_tokens.push_back(tok);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_token(input cltl_pkg::t_out got);
        cltl_pkg::t_out want;
        if (due_tokens.size() == 0) begin
            report_mismatch($sformatf("token kind %0d with none outstanding", got.token_kind));
        end else begin
            want = due_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report_mismatch($sformatf("token_kind %0d, wanted %0d",
                                          got.token_kind, want.token_kind));
            if (got.token_char !== want.token_char)
                report_mismatch($sformatf("token_char %0h, wanted %0h",
                                          got.token_char, want.token_char));
            if (got.start_line !== want.start_line)
                report_mismatch($sformatf("start_line %0d, wanted %0d",
                                          got.start_line, want.start_line));
            if (got.start_column !== want.start_column)
                report_mismatch($sformatf("start_column %0d, wanted %0d",
                                          got.start_column, want.start_column));
            if (got.token_length !== want.token_length)
                report_mismatch($sformatf("token_length %0d, wanted %0d",
                                          got.token_length, want.token_length));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
        end
    endtask

    // Output side: each transfer is checked, then a fresh stall is drawn.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                check_token(out_data);
                stall_left = calm ? 0 : $urandom_range(0, 5);
                out_stall <= (stall_left != 0);
            end else if (stall_left != 0) begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end
        end
    end

    task automatic send_item(input cltl_pkg::t_in item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        lex_char(item);
        chars_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        cltl_pkg::t_in item;
        item.character = c;
        item.is_end    = 1'b0;
        send_item(item);
    endtask

    task automatic send_end();
        cltl_pkg::t_in item;
        item.character = 8'($urandom_range(0, 255));
        item.is_end    = 1'b1;
        send_item(item);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (due_tokens.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) word_char = 8'(8'h61 + r);
        else if (r < 52) word_char = 8'(8'h41 + r - 26);
        else if (r == 52) word_char = "_";
        else word_char = 8'(8'h30 + r - 53);
    endfunction

    // One piece of source text: mostly well-formed tokens, some noise.
    task automatic send_fragment();
        int          pick;
        int          n;
        int          i;
        string       word;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
            send_byte(word_char(1'b1));
            for (i = 1; i < n; i++) send_byte(word_char(1'b0));
        end else if (pick < 30) begin
            case ($urandom_range(0, 4))
                0:       word = "if";
                1:       word = "else";
                2:       word = "while";
                3:       word = "do";
                default: word = "for";
            endcase
            if ($urandom_range(0, 5) == 0) word = word.substr(0, word.len() - 2);
            send_text(word);
            if ($urandom_range(0, 3) == 0) send_byte(word_char(1'b0));
        end else if (pick < 38) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) send_byte(8'(8'h30 + $urandom_range(0, 9)));
        end else if (pick < 62) begin
            send_text(op_set[$urandom_range(0, 47)]);
        end else if (pick < 72) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 5))
                    0:       b = 8'h09;
                    1:       b = cltl_pkg::CH_VTAB;
                    2:       b = 8'h0c;
                    3:       b = 8'h0d;
                    4:       b = CH_NL;
                    default: b = 8'h20;
                endcase
                send_byte(b);
            end
        end else if (pick < 76) begin
            send_text("//");
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NL);
        end else if (pick < 80) begin
            send_text("/*");
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       b = "*";
                    1:       b = "/";
                    2:       b = "a";
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b);
            end
            send_text("*/");
        end else if (pick < 84) begin
            send_text("..");
            case ($urandom_range(0, 3))
                0:       b = ".";
                1:       b = "x";
                2:       b = 8'h20;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end else if (pick < 97) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_end();
        end
        if ($urandom_range(0, 2) == 0) send_byte(8'h20);
    endtask

    task automatic test_directed_tokens();
        send_text("if(x1<<=..a/*/**/");
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(cltl_pkg::CH_VTAB);
        send_text("//");
        send_byte(CH_NL);
        send_text("e");
        send_end();
    endtask

    task automatic test_random_text(input int target);
        int goal;
        goal = chars_sent + target;
        while (chars_sent < goal) begin
            if ($urandom_range(0, 49) == 0) calm = ~calm;
            send_fragment();
        end
        calm = 1'b0;
    endtask

    task automatic test_paused_sender();
        int round;
        int k;
        for (round = 0; round < 4; round++) begin
            for (k = 0; k < 15; k++) send_fragment();
            wait_idle();
        end
    endtask

    task automatic test_long_runs();
        int i;
        calm = 1'b1;
        send_end();
        for (i = 0; i < 40; i++) send_byte("a");
        send_text(" b");
        for (i = 0; i < 20; i++) send_byte(CH_NL);
        send_text("c");
        send_end();
        calm = 1'b0;
        wait_idle();
    endtask

    initial begin
        reset_scanner();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_tokens();
        test_random_text(900);
        test_paused_sender();
        test_long_runs();
        wait_idle();
        if (mismatches == 0 && due_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/cltl_pkg.sv
src/c_like_token_lexer.sv
test/c_like_token_lexer_test.sv
